// ===== sv/f2si_pkg.sv =====
`timescale 1ns / 1ps

package f2si_pkg;

  // field widths
  localparam int unsigned RawW     = 32;
  localparam int unsigned ScaleW   = 20;
  localparam int unsigned MantW    = 24;
  localparam int unsigned ExpW     = 8;
  localparam int unsigned ProdW    = MantW + ScaleW;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned MagW     = ValueW - 1;
  localparam int unsigned AmtW     = 6;

  // stream widths, rounded up to whole bytes
  localparam int unsigned InDataW  = ((RawW + ScaleW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ValueW;

  // exponent handling
  localparam logic [ExpW-1:0] ShiftBias = 8'd150;
  localparam logic [ExpW-1:0] ExpOnes   = 8'hff;
  localparam logic [ExpW-1:0] MaxLeft   = 8'd31;
  // beyond this right shift the rounded result is always zero
  localparam logic [ExpW-1:0] MaxRight  = 8'(ProdW + 1);

  localparam int unsigned WideW = ProdW + 31;

  localparam logic [MagW-1:0] MagSat = '1;

endpackage

// ===== sv/float32_to_scaled_integer_top.sv =====
`timescale 1ns / 1ps

// Converts a stream of IEEE754 single-precision words into signed integers
// scaled by a per-beat unsigned factor: the 24-bit mantissa (implicit one
// always set) is multiplied by the scale and shifted by exponent minus 150,
// rounding half up on right shifts. Zero, infinity and NaN give 0; left
// shifts past 31 give 0; a left-shifted magnitude beyond 2^63-1 saturates
// and raises the overflow flag in tuser. The datapath is a four-stage
// pipeline (multiply, shift, round, sign), so one beat is taken every cycle
// while the output side is not stalled, and each result passes through the
// stage registers in that order. Each stage holds its beat independently, so
// a stall on the output only stops the stages that are full behind it.
module float32_to_scaled_integer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] raw_word, [51:32] scale, [55:52] zero
  input  logic [f2si_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [63:0] value
  output logic [f2si_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [0] overflow
  output logic                           m_axis_tuser_o
);
  import f2si_pkg::*;

  // stage enables, back to front
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4 = !v4_q || m_axis_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  // stage 1: decode and multiply
  logic [RawW-1:0]   raw;
  logic [ScaleW-1:0] scl;
  logic [ExpW-1:0]   expf;
  logic [MantW-1:0]  mant;
  logic [ExpW-1:0]   lsh, rsh;
  logic              left_d, kill_d;
  logic [AmtW-1:0]   amt_d;
  logic [ProdW-1:0]  prod_d;

  logic              neg1_q, left1_q, kill1_q;
  logic [AmtW-1:0]   amt1_q;
  logic [ProdW-1:0]  prod1_q;

  always_comb begin
    raw    = s_axis_tdata_i[RawW-1:0];
    scl    = s_axis_tdata_i[RawW+ScaleW-1:RawW];
    expf   = raw[30:23];
    mant   = {1'b1, raw[22:0]};
    prod_d = ProdW'(mant) * ProdW'(scl);
    lsh    = expf - ShiftBias;
    rsh    = ShiftBias - expf;
    left_d = expf >= ShiftBias;
    kill_d = (raw[30:0] == '0) || (expf == ExpOnes);
    if (left_d) begin
      if (lsh > MaxLeft) kill_d = 1'b1;
      amt_d = lsh[AmtW-1:0];
    end else begin
      if (rsh > MaxRight) kill_d = 1'b1;
      // shift by r-1 here, the last bit goes after the rounding add
      amt_d = AmtW'(rsh - 8'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      neg1_q  <= raw[31];
      left1_q <= left_d;
      kill1_q <= kill_d;
      amt1_q  <= amt_d;
      prod1_q <= prod_d;
    end
  end

  // stage 2: barrel shift and overflow check
  logic [WideW-1:0] wide;
  logic [MagW-1:0]  mag2_d;
  logic             rnd2_d, ovf2_d;

  logic             neg2_q, rnd2_q, ovf2_q;
  logic [MagW-1:0]  mag2_q;

  always_comb begin
    wide   = WideW'(prod1_q) << amt1_q[4:0];
    mag2_d = '0;
    rnd2_d = 1'b0;
    ovf2_d = 1'b0;
    if (kill1_q) begin
      mag2_d = '0;
    end else if (left1_q) begin
      if (|wide[WideW-1:MagW]) begin
        mag2_d = MagSat;
        ovf2_d = 1'b1;
      end else begin
        mag2_d = wide[MagW-1:0];
      end
    end else begin
      mag2_d = MagW'(prod1_q >> amt1_q);
      rnd2_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      neg2_q <= neg1_q;
      rnd2_q <= rnd2_d;
      ovf2_q <= ovf2_d;
      mag2_q <= mag2_d;
    end
  end

  // stage 3: round half up on right shifts
  logic [ProdW:0]  inc;
  logic [MagW-1:0] mag3_d;

  logic            neg3_q, ovf3_q;
  logic [MagW-1:0] mag3_q;

  always_comb begin
    inc    = {1'b0, mag2_q[ProdW-1:0]} + 1'b1;
    mag3_d = rnd2_q ? MagW'(inc[ProdW:1]) : mag2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      neg3_q <= neg2_q;
      ovf3_q <= ovf2_q;
      mag3_q <= mag3_d;
    end
  end

  // stage 4: apply sign into the output register
  logic [ValueW-1:0] value_d;
  logic [ValueW-1:0] value_q;
  logic              ovf4_q;

  assign value_d = neg3_q ? (ValueW'(0) - {1'b0, mag3_q}) : {1'b0, mag3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      value_q <= value_d;
      ovf4_q  <= ovf3_q;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = value_q;
  assign m_axis_tuser_o  = ovf4_q;

endmodule

// ===== tb/tb_float32_to_scaled_integer_top.sv =====
`timescale 1ns / 1ps

module tb_float32_to_scaled_integer_top;

  localparam int          RandomWords = 800;
  localparam int          QuietTail   = 120;
  localparam int          ExpBias     = 150;
  localparam int          LeftLimit   = 31;
  localparam int          RightLimit  = 62;
  localparam logic [63:0] MagLimit    = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [f2si_pkg::ScaleW-1:0] scale;
    logic [f2si_pkg::RawW-1:0]   raw;
  } conv_req_t;

  typedef struct packed {
    logic [f2si_pkg::ValueW-1:0] value;
    logic                        overflow;
  } conv_res_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_axis_tready_o;
  logic [f2si_pkg::InDataW-1:0]  s_tdata = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_tready = 1'b0;
  logic [f2si_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          m_axis_tuser_o;

  conv_req_t pending_words[$];
  conv_res_t expected_results[$];
  conv_req_t cur_req;
  logic      beat_taken = 1'b0;
  logic      long_hold = 1'b0;
  int        send_gap = 0;
  int        recv_stall = 0;
  int        beats_in = 0;
  int        total_words = 0;
  int        mismatch_count = 0;

  float32_to_scaled_integer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic conv_res_t scale_float_word(conv_req_t req);
    conv_res_t   res;
    logic [7:0]  exp_field;
    logic [63:0] mant;
    logic [63:0] prod;
    logic [63:0] half;
    int          shift_amt;
    res = '0;
    exp_field = req.raw[30:23];
    if (req.raw[30:0] != '0 && exp_field != f2si_pkg::ExpOnes) begin
      // implicit one stays set, subnormals included
      mant = {40'd0, 1'b1, req.raw[22:0]};
      prod = mant * {44'd0, req.scale};
      shift_amt = int'(exp_field) - ExpBias;
      if (shift_amt >= 0) begin
        if (shift_amt <= LeftLimit) begin
          if (prod > (MagLimit >> shift_amt)) begin
            res.value = MagLimit;
            res.overflow = 1'b1;
          end else begin
            res.value = prod << shift_amt;
          end
        end
      end else if (-shift_amt <= RightLimit) begin
        half = 64'd1 << (-shift_amt - 1);
        res.value = (prod + half) >> (-shift_amt);
      end
    end
    if (req.raw[31]) res.value = -res.value;
    return res;
  endfunction

  function automatic conv_req_t random_word();
    conv_req_t req;
    int        pick;
    req.raw = $urandom();
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      // zero, infinity or nan
      req.raw[30:23] = ($urandom_range(0, 1) == 0) ? 8'h00 : f2si_pkg::ExpOnes;
      if (req.raw[30:23] == 8'h00) req.raw[22:0] = '0;
    end else if (pick == 1) begin
      req.raw[30:23] = 8'h00;
    end else if (pick > 4) begin
      // the band where rounding, exact shifts and saturation happen
      req.raw[30:23] = 8'($urandom_range(86, 184));
    end
    pick = $urandom_range(0, 7);
    case (pick)
      0: req.scale = 20'd1000;
      1: req.scale = 20'd1000000;
      2: req.scale = 20'($urandom());
      3: req.scale = 20'($urandom_range(0, 15));
      default: req.scale = 20'($urandom_range(0, 1000000));
    endcase
    return req;
  endfunction

  task automatic queue_word(logic [31:0] raw, logic [19:0] scale);
    conv_req_t req;
    req.raw = raw;
    req.scale = scale;
    pending_words.push_back(req);
  endtask

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (mismatch_count < 10)
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // sender: new beat once the current one is taken, random gaps in between
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beat_taken) begin
      beat_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur_req = pending_words.pop_front();
        s_tdata <= f2si_pkg::InDataW'({cur_req.scale, cur_req.raw});
        s_tvalid <= 1'b1;
        if (pending_words.size() >= QuietTail && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 10);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni || long_hold) begin
      m_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall = recv_stall - 1;
      m_tready <= 1'b0;
    end else if (pending_words.size() >= QuietTail && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // long back-pressure so the pipeline fills and stalls the input
  initial begin
    while (beats_in < 200) @(negedge clk_i);
    long_hold = 1'b1;
    repeat (80) @(negedge clk_i);
    long_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    conv_res_t want;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        expected_results.push_back(scale_float_word(cur_req));
        beats_in++;
        beat_taken = 1'b1;
      end
      if (m_axis_tvalid_o && m_tready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected beat, value", 'x, m_axis_tdata_o);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata_o !== want.value)
            note_mismatch("value", want.value, m_axis_tdata_o);
          if (m_axis_tuser_o !== want.overflow)
            note_mismatch("overflow", 64'(want.overflow), 64'(m_axis_tuser_o));
        end
      end
    end
  end

  initial begin
    queue_word(32'h0000_0000, 20'd1000);
    queue_word(32'h8000_0000, 20'd1000000);
    queue_word(32'h7f80_0000, 20'd1000);
    queue_word(32'hff80_0000, 20'd1000);
    queue_word(32'h7fc0_0001, 20'hfffff);
    queue_word(32'hffff_ffff, 20'hfffff);
    queue_word(32'h0000_0001, 20'hfffff);
    queue_word(32'h807f_ffff, 20'hfffff);
    queue_word(32'h3f80_0000, 20'd1000);
    queue_word(32'hbf80_0000, 20'd1000000);
    // exact halves round up on the magnitude
    queue_word(32'h3f00_0000, 20'd1);
    queue_word(32'hbf00_0000, 20'd1);
    queue_word(32'h3eff_ffff, 20'd1);
    queue_word({1'b0, 8'd150, 23'd0}, 20'd1);
    queue_word({1'b0, 8'd181, 23'h7fffff}, 20'hfffff);
    queue_word({1'b1, 8'd181, 23'h7fffff}, 20'hfffff);
    queue_word({1'b0, 8'd181, 23'd0}, 20'd1);
    queue_word({1'b0, 8'd182, 23'd0}, 20'd1000);
    queue_word({1'b0, 8'hfe, 23'h7fffff}, 20'hfffff);
    queue_word({1'b0, 8'd88, 23'h7fffff}, 20'hfffff);
    queue_word({1'b0, 8'd87, 23'h7fffff}, 20'hfffff);
    queue_word(32'h3f80_0000, 20'd0);
    queue_word(32'ha5a5_a5a5, 20'h5a5a5);
    queue_word(32'h5a5a_5a5a, 20'ha5a5a);
    repeat (RandomWords) pending_words.push_back(random_word());
    total_words = pending_words.size();

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    while (beats_in < total_words) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_float32_to_scaled_integer_top passed");
    end else begin
      $display("tb_float32_to_scaled_integer_top failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_float32_to_scaled_integer_top failed");
    $finish;
  end

endmodule
